// ===== hw/rtl/csv_record_field_parser_defines.svh =====
// ----------------------------------------------------------------------------
// csv_record_field_parser_defines.svh
// Assertion macros used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_FIELD_PARSER_DEFINES_SVH
`define CSV_RECORD_FIELD_PARSER_DEFINES_SVH

// clocked check, switched off while reset is high
`define CSVP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define CSVP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg
// Types and constants of the CSV record field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_FIELD   = 2'd1;
   localparam logic [1:0] KIND_REC_OK  = 2'd2;
   localparam logic [1:0] KIND_REC_ERR = 2'd3;

   // character codes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_N      = 8'h6E;

   // output queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] column;
      logic       last;
   } rsp_item_type;

   // what one parsed byte hands to the output queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_type;

   typedef struct packed {
      logic               room;   // space for two more words
      logic [OUTQ_LW-1:0] level;
   } outq_status_type;

endpackage

// ===== hw/rtl/csvp_channels.sv =====
// ----------------------------------------------------------------------------
// csvp channels
// Valid/ready channel interfaces for input bytes, results and the register.
// ----------------------------------------------------------------------------
interface csvp_req_if import csvp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface csvp_rsp_if import csvp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [7:0] column;
   logic       last;

   modport source (output valid, output kind, output data_byte, output column,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input column,
                   input last, output ready);
endinterface

interface csvp_csr_if import csvp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] fields_per_record;

   modport source (output valid, output fields_per_record, input ready);
   modport sink   (input valid, input fields_per_record, output ready);
endinterface

// ===== hw/rtl/csv_record_field_parser.sv =====
// ----------------------------------------------------------------------------
// csv_record_field_parser
// Splits a CSV byte stream into field data words, field ends and record ends.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                              | word
//   ---------+-----+--------------------------------------+-------------------
//   req_ch   | in  | in_byte[7:0]                         | one text byte
//   rsp_ch   | out | kind[1:0] data_byte column[7:0] last | one parse result
//   csr_ch   | in  | fields_per_record[7:0]               | register write
//
// - One byte accepted per cycle while the queue has room; a byte is parsed
//   while it sits in the input register and its words enter the result queue.
// - Sustained output is one word per cycle from the single queue read port
//   while rsp_ch is ready, so bytes that give two words (unknown escape, held
//   quote plus data) slow the input side only while the queue is near full.
// - reset is synchronous, active high; fields_per_record returns to 1.
// - A stalled rsp_ch stops parsing once the four-word queue holds three or
//   more words; the input register then keeps its byte and req_ch.ready drops.
// - csr_ch is always ready; write it only while the parser is idle.
//
`include "csv_record_field_parser_defines.svh"

module csv_record_field_parser import csvp_pkg::*; (
   input logic      clock,
   input logic      reset,
   csvp_req_if.sink   req_ch,
   csvp_rsp_if.source rsp_ch,
   csvp_csr_if.sink   csr_ch
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       consume;

   // configuration
   logic [7:0] fpr_ff;

   step_type        step;
   rsp_item_type    head;
   logic            head_valid;
   logic            pop;
   outq_status_type q_status;

   // csr channel: a single register, always writable
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpr_ff <= 8'd1;
      end else if (csr_ch.valid) begin
         fpr_ff <= csr_ch.fields_per_record;
      end
   end

   // a byte moves on once the queue can hold everything it may produce
   assign consume      = in_vld_ff && q_status.room;
   assign req_ch.ready = !in_vld_ff || consume;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_vld_in    = req_take || (in_vld_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.in_byte;
      end
   end

   csvp_core u_core (
      .clock             (clock),
      .reset             (reset),
      .step_en           (consume),
      .in_byte           (in_byte_ff),
      .fields_per_record (fpr_ff),
      .step              (step)
   );

   csvp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .status     (q_status)
   );

   // result channel straight from the queue head
   assign pop              = head_valid && rsp_ch.ready;
   assign rsp_ch.valid     = head_valid;
   assign rsp_ch.kind      = head.kind;
   assign rsp_ch.data_byte = head.data_byte;
   assign rsp_ch.column    = head.column;
   assign rsp_ch.last      = head.last;

   // ---- checks ----
   `CSVP_ASSERT(a_q_level, clock, reset, q_status.level <= OUTQ_LW'(OUTQ_DEPTH), "queue overflow")
   `CSVP_ASSERT(a_in_hold, clock, reset, in_vld_ff && !consume |=> in_vld_ff && $stable(in_byte_ff), "held byte lost")
   `CSVP_ASSERT(a_pair_data, clock, reset, step.count == 2'd2 |-> step.item0.kind == KIND_DATA && step.item1.kind == KIND_DATA, "two words must both be data")
   `CSVP_ASSERT(a_nodata_zero, clock, reset, rsp_ch.valid && rsp_ch.kind != KIND_DATA |-> rsp_ch.data_byte == 8'd0, "non-data word carries data")

endmodule

// ===== hw/rtl/csvp_core.sv =====
// ----------------------------------------------------------------------------
// csvp_core
// Parse state and per-byte decode; yields up to two result words a byte.
// ----------------------------------------------------------------------------
module csvp_core import csvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] in_byte,
   input  logic [7:0] fields_per_record,
   output step_type   step
);

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;
   localparam logic [1:0] MODE_SKIP   = 2'd3;

   logic [1:0] mode_ff, mode_in;
   logic       qp_ff, qp_in;     // quote seen inside quoted field
   logic       ep_ff, ep_in;     // backslash seen inside quoted field
   logic       cr_ff, cr_in;     // previous line ended with CR
   logic [7:0] col_ff, col_in;

   logic [7:0]   need;
   logic [8:0]   col_inc;
   logic         last_col;
   logic         eol;
   logic         do_comma;
   logic         rec_err;
   logic [1:0]   n;
   rsp_item_type a0, a1;

   function automatic rsp_item_type mk(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [7:0] col);
      rsp_item_type it;
      it.kind      = kind;
      it.data_byte = data;
      it.column    = col;
      it.last      = 1'b0;
      return it;
   endfunction

   assign need     = (fields_per_record == 8'd0) ? 8'd1 : fields_per_record;
   assign col_inc  = {1'b0, col_ff} + 9'd1;
   assign last_col = (col_inc >= {1'b0, need});
   assign eol      = (in_byte == CH_CR) || (in_byte == CH_LF);
   assign rec_err  = (mode_ff != MODE_SKIP) &&
                     ((mode_ff == MODE_START) || ((mode_ff == MODE_QUOTED) && !qp_ff) ||
                      !last_col);

   always_comb begin
      mode_in  = mode_ff;
      qp_in    = qp_ff;
      ep_in    = ep_ff;
      cr_in    = 1'b0;
      col_in   = col_ff;
      do_comma = 1'b0;
      n        = 2'd0;
      a0       = mk(KIND_DATA, 8'd0, col_ff);
      a1       = mk(KIND_DATA, 8'd0, col_ff);

      if (cr_ff && (in_byte == CH_LF)) begin
         // LF of a CR LF pair: dropped
      end else if (eol) begin
         a0     = mk(rec_err ? KIND_REC_ERR : KIND_REC_OK, 8'd0, col_ff);
         n      = 2'd1;
         mode_in = MODE_START;
         qp_in  = 1'b0;
         ep_in  = 1'b0;
         col_in = 8'd0;
         cr_in  = (in_byte == CH_CR);
      end else begin
         case (mode_ff)
            MODE_SKIP: begin
            end
            MODE_START: begin
               if (in_byte == CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else if (in_byte == CH_COMMA) begin
                  do_comma = 1'b1;
               end else begin
                  mode_in = MODE_PLAIN;
                  a0      = mk(KIND_DATA, in_byte, col_ff);
                  n       = 2'd1;
               end
            end
            MODE_PLAIN: begin
               if (in_byte == CH_COMMA) begin
                  do_comma = 1'b1;
               end else begin
                  a0 = mk(KIND_DATA, in_byte, col_ff);
                  n  = 2'd1;
               end
            end
            MODE_QUOTED: begin
               if (ep_ff) begin
                  ep_in = 1'b0;
                  n     = 2'd1;
                  if (in_byte == CH_R) begin
                     a0 = mk(KIND_DATA, CH_CR, col_ff);
                  end else if (in_byte == CH_N) begin
                     a0 = mk(KIND_DATA, CH_LF, col_ff);
                  end else if ((in_byte == CH_BSLASH) || (in_byte == CH_QUOTE)) begin
                     a0 = mk(KIND_DATA, in_byte, col_ff);
                  end else begin
                     // unknown escape keeps its backslash
                     a0 = mk(KIND_DATA, CH_BSLASH, col_ff);
                     a1 = mk(KIND_DATA, in_byte, col_ff);
                     n  = 2'd2;
                  end
               end else if (qp_ff) begin
                  if (in_byte == CH_COMMA) begin
                     do_comma = 1'b1;
                  end else begin
                     // the held quote was data after all
                     qp_in = 1'b0;
                     a0    = mk(KIND_DATA, CH_QUOTE, col_ff);
                     n     = 2'd1;
                     if (in_byte == CH_QUOTE) begin
                        qp_in = 1'b1;
                     end else if (in_byte == CH_BSLASH) begin
                        ep_in = 1'b1;
                     end else begin
                        a1 = mk(KIND_DATA, in_byte, col_ff);
                        n  = 2'd2;
                     end
                  end
               end else begin
                  if (in_byte == CH_QUOTE) begin
                     qp_in = 1'b1;
                  end else if (in_byte == CH_BSLASH) begin
                     ep_in = 1'b1;
                  end else begin
                     a0 = mk(KIND_DATA, in_byte, col_ff);
                     n  = 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (do_comma) begin
            a0    = mk(KIND_FIELD, 8'd0, col_ff);
            n     = 2'd1;
            qp_in = 1'b0;
            ep_in = 1'b0;
            if (last_col) begin
               mode_in = MODE_SKIP;
            end else begin
               col_in  = col_inc[7:0];
               mode_in = MODE_START;
            end
         end
      end
   end

   always_comb begin
      step.count      = step_en ? n : 2'd0;
      step.item0      = a0;
      step.item0.last = (n == 2'd1);
      step.item1      = a1;
      step.item1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         qp_ff   <= 1'b0;
         ep_ff   <= 1'b0;
         cr_ff   <= 1'b0;
         col_ff  <= 8'd0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         qp_ff   <= qp_in;
         ep_ff   <= ep_in;
         cr_ff   <= cr_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ===== hw/rtl/csvp_outq.sv =====
// ----------------------------------------------------------------------------
// csvp_outq
// Small result queue: takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module csvp_outq import csvp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  step_type        push,
   input  logic            pop,
   output rsp_item_type    head,
   output logic            head_valid,
   output outq_status_type status
);

   rsp_item_type       mem_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [OUTQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_LW-1:0] level_ff, level_in;

   assign wr_ptr_nx  = wr_ptr_ff + OUTQ_AW'(1);
   assign wr_ptr_in  = wr_ptr_ff + OUTQ_AW'(push.count);
   assign rd_ptr_in  = rd_ptr_ff + OUTQ_AW'(pop);
   assign level_in   = level_ff + OUTQ_LW'(push.count) - OUTQ_LW'(pop);

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);

   assign status.level = level_ff;
   assign status.room  = (level_ff <= OUTQ_LW'(OUTQ_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule
